// ===== design/rvc_pkg.sv =====
// Shared types, codes and constants for the replica vote collector.
// Standalone package; used by design/replica_vote_collector.sv.
package rvc_pkg;

  // Replica set and field widths
  localparam int NUM_REPLICAS = 3;
  localparam int REP_W     = 2;
  localparam int WORD_W    = 64;
  localparam int MAX_RES   = 3;
  localparam int CNT_W     = 2;
  localparam int WARM_W    = 4;
  localparam int TMO_W     = 24;
  localparam int OP_W      = 3;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;

  // Stream payload widths, rounded up to whole bytes
  localparam int S_FIELDS_W = REP_W + 3 * WORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * REP_W + 3 * WORD_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [WARM_W-1:0] WARMUP_RESET  = 4'd4;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 24'd10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SENSOR   = 3'd0,
    OP_VOTE     = 3'd1,
    OP_TICK     = 3'd2,
    OP_GOAL_REQ = 3'd3,
    OP_NEW_GOAL = 3'd4
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMMAND   = 3'd0,
    KIND_RESTART   = 3'd1,
    KIND_GOAL      = 3'd2,
    KIND_DUP_REQ   = 3'd3,
    KIND_CHANGED   = 3'd4,
    KIND_DISAGREE  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [REP_W-1:0]   target;
    logic [REP_W-1:0]   helper;
    logic [WORD_W-1:0]  out_a;
    logic [WORD_W-1:0]  out_b;
    logic [WORD_W-1:0]  out_c;
    logic               last;
  } res_t;

  // Neighbour that restarts replica i: the previous one, wrapping round
  function automatic logic [REP_W-1:0] prev_rep(input int i);
    logic [REP_W-1:0] p;
    if (i == 0) begin
      p = REP_W'(NUM_REPLICAS - 1);
    end else begin
      p = REP_W'(i - 1);
    end
    return p;
  endfunction

  // Build one result entry, last flag clear
  function automatic res_t mk_res(input kind_t k, input logic [REP_W-1:0] t,
                                  input logic [REP_W-1:0] h,
                                  input logic [WORD_W-1:0] a,
                                  input logic [WORD_W-1:0] b,
                                  input logic [WORD_W-1:0] c);
    res_t r;
    r.kind   = k;
    r.target = t;
    r.helper = h;
    r.out_a  = a;
    r.out_b  = b;
    r.out_c  = c;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/replica_vote_collector.sv =====
// Replica vote collector: event-driven unanimity voter with timeout restarts
// and gated goal distribution. Depends on design/rvc_pkg.sv.
// A request accepted on s_axis passes the input register and then the result
// stage before its first result shows on m_axis, when the result stage is free.
// One request per cycle while the result stage is free; a request giving n
// results (at most 3) holds the result stage until all leave by the single result output port.
// Reset (rst, synchronous): vote, timer, warm-up and goal state cleared,
// registers to warm-up 4 and timeout 10000, both stream stages emptied.
module replica_vote_collector (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: replica[1:0], word_a[65:2], word_b[129:66], word_c[193:130]
  input  logic [rvc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser: opcode[2:0]
  input  logic [rvc_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, low bit up: target[1:0], helper[3:2], out_a[67:4], out_b[131:68],
  // out_c[195:132]
  output logic [rvc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // tuser: kind[2:0]
  output logic [rvc_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvc_pkg::TMO_W-1:0]        cfg_data
);

  localparam int RC = rvc_pkg::NUM_REPLICAS;
  localparam int WW = rvc_pkg::WORD_W;
  localparam int RW = rvc_pkg::REP_W;

  // Configuration registers
  logic [rvc_pkg::WARM_W-1:0] warmup_rounds;
  logic [rvc_pkg::TMO_W-1:0]  vote_timeout_ticks;

  // Input register
  logic                       in_valid;
  rvc_pkg::opcode_t           in_op;
  logic [RW-1:0]              in_rep;
  logic [WW-1:0]              in_word_a;
  logic [WW-1:0]              in_word_b;
  logic [WW-1:0]              in_word_c;

  // Block state
  logic                       voting_open;
  logic [RC-1:0]              has_voted;
  logic [WW-1:0]              vote_speed [RC];
  logic [WW-1:0]              vote_turn  [RC];
  logic [rvc_pkg::WARM_W-1:0] warmup_count;
  logic                       timer_armed;
  logic [rvc_pkg::TMO_W-1:0]  timer_left;
  logic [RC-1:0]              goal_sent;
  logic [WW-1:0]              current_goal [3];

  // Next state
  logic                       voting_open_next;
  logic [RC-1:0]              has_voted_next;
  logic [WW-1:0]              vote_speed_next [RC];
  logic [WW-1:0]              vote_turn_next  [RC];
  logic [rvc_pkg::WARM_W-1:0] warmup_count_next;
  logic                       timer_armed_next;
  logic [rvc_pkg::TMO_W-1:0]  timer_left_next;
  logic [RC-1:0]              goal_sent_next;
  logic                       goal_load;
  logic                       vote_done;

  // Result stage
  rvc_pkg::res_t              res [rvc_pkg::MAX_RES];
  logic [rvc_pkg::CNT_W-1:0]  res_cnt;
  rvc_pkg::res_t              res_next [rvc_pkg::MAX_RES];
  logic [rvc_pkg::CNT_W-1:0]  res_cnt_next;

  logic                       res_free;
  logic                       process;
  logic                       pop;
  logic                       rep_ok;

  // Handshakes
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign res_free      = (res_cnt == '0) ||
                         ((res_cnt == rvc_pkg::CNT_W'(1)) && m_axis_tready);
  assign process       = in_valid && res_free;
  assign s_axis_tready = !in_valid || process;
  assign cfg_ready     = 1'b1;
  assign rep_ok        = (in_rep < RW'(RC));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_rounds      <= rvc_pkg::WARMUP_RESET;
      vote_timeout_ticks <= rvc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rvc_pkg::CFG_WARMUP:  warmup_rounds      <= cfg_data[rvc_pkg::WARM_W-1:0];
        rvc_pkg::CFG_TIMEOUT: vote_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: take a request whenever the stage empties
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op     <= rvc_pkg::opcode_t'(s_axis_tuser);
      in_rep    <= s_axis_tdata[RW-1:0];
      in_word_a <= s_axis_tdata[RW +: WW];
      in_word_b <= s_axis_tdata[RW + WW +: WW];
      in_word_c <= s_axis_tdata[RW + 2*WW +: WW];
    end
  end

  // Event decode: next state and the results of the held request
  always_comb begin
    logic all_in;
    logic agree;
    logic [rvc_pkg::CNT_W-1:0] n;

    voting_open_next  = voting_open;
    has_voted_next    = has_voted;
    vote_speed_next   = vote_speed;
    vote_turn_next    = vote_turn;
    warmup_count_next = warmup_count;
    timer_armed_next  = timer_armed;
    timer_left_next   = timer_left;
    goal_sent_next    = goal_sent;
    goal_load         = 1'b0;
    vote_done         = 1'b0;
    all_in            = 1'b0;
    agree             = 1'b1;
    n                 = '0;
    for (int r = 0; r < rvc_pkg::MAX_RES; r++) begin
      res_next[r] = rvc_pkg::mk_res(rvc_pkg::KIND_COMMAND, '0, '0, '0, '0, '0);
    end

    case (in_op)
      rvc_pkg::OP_SENSOR: begin
        // count warm-up rounds, then open the vote and load the timeout
        if (warmup_count < warmup_rounds) begin
          warmup_count_next = warmup_count + rvc_pkg::WARM_W'(1);
        end else begin
          voting_open_next = 1'b1;
          timer_armed_next = 1'b1;
          timer_left_next  = vote_timeout_ticks;
        end
      end
      rvc_pkg::OP_VOTE: begin
        if (rep_ok) begin
          // keep the first vote; flag a repeat with different words
          if (has_voted[in_rep]) begin
            if (vote_speed[in_rep] != in_word_a || vote_turn[in_rep] != in_word_b) begin
              res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_CHANGED, in_rep, '0,
                                            '0, '0, '0);
              n = n + rvc_pkg::CNT_W'(1);
            end
          end else begin
            has_voted_next[in_rep]  = 1'b1;
            vote_speed_next[in_rep] = in_word_a;
            vote_turn_next[in_rep]  = in_word_b;
          end
          // tally
          all_in = &has_voted_next;
          for (int i = 1; i < RC; i++) begin
            if (vote_speed_next[i] != vote_speed_next[0] ||
                vote_turn_next[i] != vote_turn_next[0]) begin
              agree = 1'b0;
            end
          end
          if (all_in && agree) begin
            res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_COMMAND, '0, '0,
                                          vote_speed_next[0], vote_turn_next[0], '0);
            n = n + rvc_pkg::CNT_W'(1);
            vote_done        = 1'b1;
            voting_open_next = 1'b0;
            has_voted_next   = '0;
            timer_armed_next = 1'b0;
          end else if (all_in) begin
            res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_DISAGREE, in_rep, '0,
                                          '0, '0, '0);
            n = n + rvc_pkg::CNT_W'(1);
          end
        end
      end
      rvc_pkg::OP_TICK: begin
        if (timer_armed) begin
          if (timer_left[rvc_pkg::TMO_W-1:1] == '0) begin
            // expiry: restart each silent replica, in replica order
            timer_left_next  = '0;
            timer_armed_next = 1'b0;
            if (voting_open) begin
              for (int i = 0; i < RC; i++) begin
                if (!has_voted[i] && n != rvc_pkg::CNT_W'(rvc_pkg::MAX_RES)) begin
                  res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_RESTART, RW'(i),
                                                rvc_pkg::prev_rep(i), '0, '0, '0);
                  n = n + rvc_pkg::CNT_W'(1);
                end
              end
            end
          end else begin
            timer_left_next = timer_left - rvc_pkg::TMO_W'(1);
          end
        end
      end
      rvc_pkg::OP_GOAL_REQ: begin
        if (rep_ok) begin
          if (goal_sent[in_rep]) begin
            res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_DUP_REQ, in_rep, '0,
                                          '0, '0, '0);
          end else begin
            goal_sent_next[in_rep] = 1'b1;
            res_next[n] = rvc_pkg::mk_res(rvc_pkg::KIND_GOAL, in_rep, '0,
                                          current_goal[0], current_goal[1],
                                          current_goal[2]);
          end
          n = n + rvc_pkg::CNT_W'(1);
        end
      end
      rvc_pkg::OP_NEW_GOAL: begin
        // take a new goal only when all or none have been served
        goal_load = (&goal_sent) || !(|goal_sent);
      end
      default: ;
    endcase

    // mark the final result of this request
    if (n != '0) begin
      res_next[n - rvc_pkg::CNT_W'(1)].last = 1'b1;
    end
    res_cnt_next = n;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voting_open  <= 1'b0;
      has_voted    <= '0;
      warmup_count <= '0;
      timer_armed  <= 1'b0;
      timer_left   <= '0;
      goal_sent    <= '0;
      for (int g = 0; g < 3; g++) begin
        current_goal[g] <= '0;
      end
    end else if (process) begin
      voting_open  <= voting_open_next;
      has_voted    <= has_voted_next;
      warmup_count <= warmup_count_next;
      timer_armed  <= timer_armed_next;
      timer_left   <= timer_left_next;
      goal_sent    <= goal_sent_next;
      if (goal_load) begin
        current_goal[0] <= in_word_a;
        current_goal[1] <= in_word_b;
        current_goal[2] <= in_word_c;
      end
    end
  end

  // Recorded vote words are only read behind has_voted
  always_ff @(posedge clk) begin
    if (process) begin
      vote_speed <= vote_speed_next;
      vote_turn  <= vote_turn_next;
    end
  end

  // Result stage: load a batch, or advance one entry per result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (process) begin
      res_cnt <= res_cnt_next;
    end else if (pop) begin
      res_cnt <= res_cnt - rvc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res <= res_next;
    end else if (pop) begin
      for (int r = 0; r < rvc_pkg::MAX_RES - 1; r++) begin
        res[r] <= res[r+1];
      end
    end
  end

  // Output
  assign m_axis_tvalid = (res_cnt != '0);
  assign m_axis_tuser  = res[0].kind;
  assign m_axis_tlast  = res[0].last;
  assign m_axis_tdata  = {(rvc_pkg::M_TDATA_W - rvc_pkg::M_FIELDS_W)'(0),
                          res[0].out_c, res[0].out_b, res[0].out_a,
                          res[0].helper, res[0].target};

`ifndef ASSERT_OFF
  // The result shown carries the end mark exactly when it is the final one
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (res_cnt == rvc_pkg::CNT_W'(1))))
    else $error("tlast does not match remaining result count");

  // A unanimous tally closes the vote and clears every recorded vote
  a_vote_clears: assert property (@(posedge clk) disable iff (rst)
    (process && vote_done) |=> (has_voted == '0 && !voting_open && !timer_armed))
    else $error("vote state not cleared after command");

  // A held request is never overwritten before it is processed
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !process) |=> (in_valid && $stable(in_op) && $stable(in_rep)))
    else $error("input register changed while held");

  // Served flags only ever set
  a_goal_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((goal_sent & $past(goal_sent)) == $past(goal_sent)))
    else $error("goal served flag cleared");
`endif

endmodule
